>>> design/gfr_pkg.sv
package gfr_pkg;

    // Julian day number of the J2000 epoch.
    localparam logic signed [23:0] J2000_DAY = 24'sd2451545;

    // One Julian century expressed in days times 2^8, so that a day count
    // with 32 fraction bits divided by it gives centuries with 24 fraction bits.
    localparam logic [23:0] CENT_DIV = 24'd9350400;
    localparam logic [24:0] CENT_DIV2 = 25'd18700800;

    // floor(2^54 / CENT_DIV), the reciprocal used for the century division.
    localparam logic [63:0] RECIP_FULL = (64'd1 << 54) / 64'd9350400;
    localparam logic [30:0] RECIP = RECIP_FULL[30:0];

    localparam int ATAN_COUNT = 40;
    localparam int CORDIC_STAGES_DEF = 32;

    // CORDIC datapath width: Q1.30 values plus growth headroom.
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // round(num * 2^bits / den) for num < den, by restoring long division.
    function automatic logic [63:0] frac_const(logic [63:0] num, logic [63:0] den,
                                               int bits);
        logic [63:0] r;
        logic [63:0] q;
        r = num;
        q = 64'd0;
        for (int i = 0; i < bits; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= den) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    localparam logic [63:0] C0_Q = frac_const(64'd6731054841, 64'd8640000000, 32);
    localparam logic [31:0] C0 = C0_Q[31:0];
    localparam logic [63:0] C1 = frac_const(64'd8640184812866, 64'd3155760000000000, 64);
    localparam logic [63:0] K2 = frac_const(64'd93104, 64'd86400000000, 64);
    localparam logic [63:0] K3 = frac_const(64'd62, 64'd864000000000, 64);

    // Arctangent of 2^-i in 2^-32 turns.
    function automatic logic [31:0] atan_turn(int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_pos;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
        logic [31:0]          ang;
        t_pos                 pos;
    } t_cell;

endpackage

>>> design/gfr_gmst.sv
// Ten-stage pipeline that evaluates the sidereal angle polynomial.
module gfr_gmst (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [21:0]       i_whole,
    input  logic [31:0]       i_frac,
    input  gfr_pkg::t_pos     i_pos,
    output logic              o_vld,
    output logic [31:0]       o_ang,
    output gfr_pkg::t_pos     o_pos
);

    localparam logic [27:0] C1_HI = gfr_pkg::C1[55:28];
    localparam logic [27:0] C1_LO = gfr_pkg::C1[27:0];
    localparam logic [22:0] K2_HI = gfr_pkg::K2[44:22];
    localparam logic [21:0] K2_LO = gfr_pkg::K2[21:0];
    localparam logic [30:0] K3_LO = gfr_pkg::K3[30:0];

    logic [9:0] r_vld;

    // Stage 0: signed day offset and its magnitude.
    logic signed [23:0] w_day;
    logic signed [55:0] w_d;
    logic [55:0]        w_mag;
    logic [53:0]        r0_m;
    logic               r0_neg;
    logic [31:0]        r0_frac;
    gfr_pkg::t_pos      r0_pos;

    assign w_day = $signed({2'b00, i_whole}) - gfr_pkg::J2000_DAY;
    assign w_d   = {w_day, i_frac};
    assign w_mag = w_d[55] ? 56'(-w_d) : w_d;

    // Stage 1: partial products.
    logic [54:0] r1_hh, r1_hl, r1_lh, r1_ll;
    logic [57:0] r1_qa, r1_qb;
    logic [24:0] r1_mlo;
    logic        r1_neg;
    logic [31:0] r1_frac;
    gfr_pkg::t_pos r1_pos;

    // Stage 2: full products.
    logic [109:0] r2_p;
    logic [85:0]  w_s;
    logic [30:0]  r2_q0;
    logic [24:0]  r2_mlo;
    logic         r2_neg;
    logic [31:0]  r2_frac;
    gfr_pkg::t_pos r2_pos;

    assign w_s = {1'b0, r1_qa, 27'd0} + {28'd0, r1_qb};

    // Stage 3: linear term and quotient check product.
    logic [95:0]  w_pn;
    logic [54:0]  w_prod;
    logic [31:0]  r3_t1;
    logic [24:0]  r3_prod;
    logic [30:0]  r3_q0;
    logic [24:0]  r3_mlo;
    logic         r3_neg;
    logic [31:0]  r3_frac;
    gfr_pkg::t_pos r3_pos;

    assign w_pn   = ~r2_p[95:0] + 96'd1;
    assign w_prod = r2_q0 * gfr_pkg::CENT_DIV;

    // Stage 4: corrected centuries.
    logic [24:0] w_r;
    logic [1:0]  w_corr;
    logic [30:0] r4_t24;
    logic [31:0] r4_t1;
    logic        r4_neg;
    logic [31:0] r4_frac;
    gfr_pkg::t_pos r4_pos;

    assign w_r = r3_mlo - r3_prod;
    always_comb begin
        if (w_r >= gfr_pkg::CENT_DIV2) begin
            w_corr = 2'd2;
        end else if (w_r >= {1'b0, gfr_pkg::CENT_DIV}) begin
            w_corr = 2'd1;
        end else begin
            w_corr = 2'd0;
        end
    end

    // Stage 5: T squared.
    logic [61:0] r5_t2;
    logic [30:0] r5_t24;
    logic [31:0] r5_t1;
    logic        r5_neg;
    logic [31:0] r5_frac;
    gfr_pkg::t_pos r5_pos;

    // Stage 6: products with the quadratic and cubic coefficients.
    logic [53:0] r6_hh, r6_lh;
    logic [52:0] r6_hl, r6_ll;
    logic [61:0] r6_uh, r6_ul;
    logic [30:0] r6_t24;
    logic [31:0] r6_t1;
    logic        r6_neg;
    logic [31:0] r6_frac;
    gfr_pkg::t_pos r6_pos;

    // Stage 7: sums of those products.
    logic [107:0] w_s2;
    logic [93:0]  w_s3;
    logic [27:0]  r7_t2;
    logic [29:0]  r7_u;
    logic [30:0]  r7_t24;
    logic [31:0]  r7_t1;
    logic         r7_neg;
    logic [31:0]  r7_frac;
    gfr_pkg::t_pos r7_pos;

    assign w_s2 = {1'b0, r6_hh, 53'd0} + {24'd0, r6_hl, 31'd0}
                + {32'd0, r6_lh, 22'd0} + {55'd0, r6_ll};
    assign w_s3 = {1'b0, r6_uh, 31'd0} + {32'd0, r6_ul};

    // Stage 8: cubic term.
    logic [60:0] w_t3;
    logic [20:0] r8_t3;
    logic [27:0] r8_t2;
    logic [31:0] r8_t1;
    logic        r8_neg;
    logic [31:0] r8_frac;
    gfr_pkg::t_pos r8_pos;

    assign w_t3 = r7_u * r7_t24;

    // Stage 9: angle sum modulo one turn.
    logic [31:0] w_base;
    logic [31:0] w_ang;
    logic [31:0] r9_ang;
    gfr_pkg::t_pos r9_pos;

    assign w_base = r8_frac + gfr_pkg::C0 + r8_t1 + {4'd0, r8_t2};
    assign w_ang  = r8_neg ? (w_base + {11'd0, r8_t3}) : (w_base - {11'd0, r8_t3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[8:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_m    <= w_mag[53:0];
            r0_neg  <= w_d[55];
            r0_frac <= i_frac;
            r0_pos  <= i_pos;

            r1_hh   <= r0_m[53:27] * C1_HI;
            r1_hl   <= r0_m[53:27] * C1_LO;
            r1_lh   <= r0_m[26:0] * C1_HI;
            r1_ll   <= r0_m[26:0] * C1_LO;
            r1_qa   <= r0_m[53:27] * gfr_pkg::RECIP;
            r1_qb   <= r0_m[26:0] * gfr_pkg::RECIP;
            r1_mlo  <= r0_m[24:0];
            r1_neg  <= r0_neg;
            r1_frac <= r0_frac;
            r1_pos  <= r0_pos;

            r2_p    <= {r1_hh, 55'd0} + {28'd0, r1_hl, 27'd0}
                     + {27'd0, r1_lh, 28'd0} + {55'd0, r1_ll};
            r2_q0   <= w_s[84:54];
            r2_mlo  <= r1_mlo;
            r2_neg  <= r1_neg;
            r2_frac <= r1_frac;
            r2_pos  <= r1_pos;

            r3_t1   <= r2_neg ? w_pn[95:64] : r2_p[95:64];
            r3_prod <= w_prod[24:0];
            r3_q0   <= r2_q0;
            r3_mlo  <= r2_mlo;
            r3_neg  <= r2_neg;
            r3_frac <= r2_frac;
            r3_pos  <= r2_pos;

            r4_t24  <= r3_q0 + {29'd0, w_corr};
            r4_t1   <= r3_t1;
            r4_neg  <= r3_neg;
            r4_frac <= r3_frac;
            r4_pos  <= r3_pos;

            r5_t2   <= r4_t24 * r4_t24;
            r5_t24  <= r4_t24;
            r5_t1   <= r4_t1;
            r5_neg  <= r4_neg;
            r5_frac <= r4_frac;
            r5_pos  <= r4_pos;

            r6_hh   <= r5_t2[61:31] * K2_HI;
            r6_hl   <= r5_t2[61:31] * K2_LO;
            r6_lh   <= r5_t2[30:0] * K2_HI;
            r6_ll   <= r5_t2[30:0] * K2_LO;
            r6_uh   <= r5_t2[61:31] * K3_LO;
            r6_ul   <= r5_t2[30:0] * K3_LO;
            r6_t24  <= r5_t24;
            r6_t1   <= r5_t1;
            r6_neg  <= r5_neg;
            r6_frac <= r5_frac;
            r6_pos  <= r5_pos;

            r7_t2   <= w_s2[107:80];
            r7_u    <= w_s3[93:64];
            r7_t24  <= r6_t24;
            r7_t1   <= r6_t1;
            r7_neg  <= r6_neg;
            r7_frac <= r6_frac;
            r7_pos  <= r6_pos;

            r8_t3   <= w_t3[60:40];
            r8_t2   <= r7_t2;
            r8_t1   <= r7_t1;
            r8_neg  <= r7_neg;
            r8_frac <= r7_frac;
            r8_pos  <= r7_pos;

            r9_ang  <= w_ang;
            r9_pos  <= r8_pos;
        end
    end

    assign o_vld = r_vld[9];
    assign o_ang = r9_ang;
    assign o_pos = r9_pos;

endmodule

>>> design/gfr_cell.sv
// One CORDIC rotation step; carries the rest of the item alongside.
module gfr_cell #(
    parameter int SHIFT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  gfr_pkg::t_cell  i_cell,
    output logic            o_vld,
    output gfr_pkg::t_cell  o_cell
);

    localparam logic [31:0] ATAN = gfr_pkg::atan_turn(SHIFT);
    localparam logic signed [gfr_pkg::CW-1:0] ATAN_W =
        $signed({{(gfr_pkg::CW-32){1'b0}}, ATAN});

    logic           r_vld;
    gfr_pkg::t_cell r_cell;
    gfr_pkg::t_cell n_cell;
    logic signed [gfr_pkg::CW-1:0] w_xs, w_ys;

    assign w_xs = i_cell.x >>> SHIFT;
    assign w_ys = i_cell.y >>> SHIFT;

    always_comb begin
        n_cell = i_cell;
        if (!i_cell.z[gfr_pkg::CW-1]) begin
            n_cell.x = i_cell.x - w_ys;
            n_cell.y = i_cell.y + w_xs;
            n_cell.z = i_cell.z - ATAN_W;
        end else begin
            n_cell.x = i_cell.x + w_ys;
            n_cell.y = i_cell.y - w_xs;
            n_cell.z = i_cell.z + ATAN_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_vld  = r_vld;
    assign o_cell = r_cell;

endmodule

>>> design/gfr_cordic.sv
// Quadrant fold followed by a row of CORDIC cells.
module gfr_cordic #(
    parameter int CORDIC_STAGES = gfr_pkg::CORDIC_STAGES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [31:0]     i_ang,
    input  gfr_pkg::t_pos   i_pos,
    output logic            o_vld,
    output gfr_pkg::t_cell  o_cell
);

    localparam int NCELL = (CORDIC_STAGES > gfr_pkg::ATAN_COUNT) ?
                           gfr_pkg::ATAN_COUNT : CORDIC_STAGES;

    logic [31:0]    w_a2;
    gfr_pkg::t_cell w_cell [NCELL+1];
    logic           w_vld  [NCELL+1];

    // Rotate by an eighth turn so the residual sits in [-1/8, 1/8) turn.
    assign w_a2 = i_ang + 32'h2000_0000;

    always_comb begin
        w_cell[0].x    = gfr_pkg::CORDIC_GAIN;
        w_cell[0].y    = '0;
        w_cell[0].z    = $signed({{(gfr_pkg::CW-30){1'b0}}, w_a2[29:0]})
                       - $signed({{(gfr_pkg::CW-30){1'b0}}, 30'h2000_0000});
        w_cell[0].quad = w_a2[31:30];
        w_cell[0].ang  = i_ang;
        w_cell[0].pos  = i_pos;
    end
    assign w_vld[0] = i_vld;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        gfr_cell #(
            .SHIFT(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_vld  (w_vld[g]),
            .i_cell (w_cell[g]),
            .o_vld  (w_vld[g+1]),
            .o_cell (w_cell[g+1])
        );
    end

    assign o_vld  = w_vld[NCELL];
    assign o_cell = w_cell[NCELL];

endmodule

>>> design/gfr_rot.sv
// Quadrant unfold, rotation products, rounding and saturation.
module gfr_rot (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  gfr_pkg::t_cell  i_cell,
    output logic            o_vld,
    output logic [31:0]     o_ex,
    output logic [31:0]     o_ey,
    output logic [31:0]     o_ez,
    output logic [31:0]     o_ang
);

    localparam int PW = gfr_pkg::CW + 32;

    logic signed [gfr_pkg::CW-1:0] w_c, w_s;
    logic [1:0]  r_vld;

    logic signed [PW-1:0] r_cpx, r_spy, r_cpy, r_spx;
    logic [31:0] ra_z, ra_ang;

    logic signed [PW:0]   w_sx, w_sy;
    logic signed [PW-30:0] w_qx, w_qy;
    logic [31:0] r_ex, r_ey, r_ez, r_ang;

    always_comb begin
        case (i_cell.quad)
            2'd0: begin
                w_c = i_cell.x;
                w_s = i_cell.y;
            end
            2'd1: begin
                w_c = -i_cell.y;
                w_s = i_cell.x;
            end
            2'd2: begin
                w_c = -i_cell.x;
                w_s = -i_cell.y;
            end
            default: begin
                w_c = i_cell.y;
                w_s = -i_cell.x;
            end
        endcase
    end

    function automatic logic [31:0] sat32(logic signed [PW-30:0] v);
        logic [31:0] r;
        if (v > $signed((PW-29)'(32'sh7FFF_FFFF))) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -$signed((PW-29)'(33'sh0_8000_0000))) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign w_sx = r_cpx + r_spy + (PW+1)'(33'sh0_2000_0000);
    assign w_sy = r_cpy - r_spx + (PW+1)'(33'sh0_2000_0000);
    assign w_qx = w_sx[PW:30];
    assign w_qy = w_sy[PW:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cpx  <= w_c * i_cell.pos.x;
            r_spy  <= w_s * i_cell.pos.y;
            r_cpy  <= w_c * i_cell.pos.y;
            r_spx  <= w_s * i_cell.pos.x;
            ra_z   <= i_cell.pos.z;
            ra_ang <= i_cell.ang;

            r_ex   <= sat32(w_qx);
            r_ey   <= sat32(w_qy);
            r_ez   <= ra_z;
            r_ang  <= ra_ang;
        end
    end

    assign o_vld = r_vld[1];
    assign o_ex  = r_ex;
    assign o_ey  = r_ey;
    assign o_ez  = r_ez;
    assign o_ang = r_ang;

endmodule

>>> design/gmst_frame_rotation_core.sv
// Channel  Direction  tdata fields (low bit up)                                 Width
// s        in         julian_day_whole, julian_day_fraction, pos_x, pos_y, pos_z 184
// m        out        earth_x, earth_y, earth_z, sidereal_angle                  128
//
// One request enters per clock while the output is not stalled. The pipeline is made of
// the ten-stage polynomial pipeline, one CORDIC cell per stage (at most 40 cells)
// and the two-stage product and saturation unit.
// Reset (synchronous, active low) clears only the valid bits; data registers keep junk.
// A stalled output freezes the whole pipeline, and o_s_tready drops in the same cycle.
module gmst_frame_rotation_core #(
    parameter int CORDIC_STAGES = gfr_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [21:0] julian_day_whole, [53:22] julian_day_fraction, [85:54] pos_x,
    // [117:86] pos_y, [149:118] pos_z, [183:150] zero
    input  logic [183:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] earth_x, [63:32] earth_y, [95:64] earth_z, [127:96] sidereal_angle
    output logic [127:0] o_m_tdata
);

    // All stages move together; the output register holds a result until taken,
    // and the stages behind it advance whenever that register is free or drains.
    logic w_adv;
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    gfr_pkg::t_pos w_in_pos;
    assign w_in_pos.x = i_s_tdata[85:54];
    assign w_in_pos.y = i_s_tdata[117:86];
    assign w_in_pos.z = i_s_tdata[149:118];

    // Sidereal angle in 2^-32 turns, with the position carried alongside.
    logic          w_gmst_vld;
    logic [31:0]   w_gmst_ang;
    gfr_pkg::t_pos w_gmst_pos;

    gfr_gmst u_gmst (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_vld  (i_s_tvalid),
        .i_whole(i_s_tdata[21:0]),
        .i_frac (i_s_tdata[53:22]),
        .i_pos  (w_in_pos),
        .o_vld  (w_gmst_vld),
        .o_ang  (w_gmst_ang),
        .o_pos  (w_gmst_pos)
    );

    // Cosine and sine of the folded angle, one CORDIC iteration per cell.
    logic           w_cordic_vld;
    gfr_pkg::t_cell w_cordic_cell;

    gfr_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_vld  (w_gmst_vld),
        .i_ang  (w_gmst_ang),
        .i_pos  (w_gmst_pos),
        .o_vld  (w_cordic_vld),
        .o_cell (w_cordic_cell)
    );

    // Rotation about z, rounded half up and saturated; this is the output register.
    logic [31:0] w_ex, w_ey, w_ez, w_ang;

    gfr_rot u_rot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_vld  (w_cordic_vld),
        .i_cell (w_cordic_cell),
        .o_vld  (o_m_tvalid),
        .o_ex   (w_ex),
        .o_ey   (w_ey),
        .o_ez   (w_ez),
        .o_ang  (w_ang)
    );

    assign o_m_tdata = {w_ang, w_ez, w_ey, w_ex};

    // A held result must block new requests.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("request accepted while output stalled");

    // While stalled, no item moves inside the pipeline.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(w_gmst_vld) && $stable(w_cordic_vld)))
        else $error("pipeline moved during stall");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

>>> tb/gfr_checker.sv
module gfr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // [21:0] julian_day_whole, [53:22] julian_day_fraction, [85:54] pos_x,
    // [117:86] pos_y, [149:118] pos_z, [183:150] zero
    input  logic [183:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // [31:0] earth_x, [63:32] earth_y, [95:64] earth_z, [127:96] sidereal_angle
    input  logic [127:0] i_m_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked
);

    localparam int ROT_STAGES = 32;
    localparam longint EPOCH_DAY = 64'sd2451545;
    localparam logic [63:0] CENTURY_Q24 = 64'd9350400;
    localparam longint GAIN_Q30 = 64'sd652032874;

    typedef struct packed {
        logic signed [31:0] earth_x;
        logic signed [31:0] earth_y;
        logic signed [31:0] earth_z;
        logic [31:0]        angle;
    } t_earth_pos;

    logic [31:0] atan_tbl [0:39] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    t_earth_pos earth_q [$];

    // Nearest rounding of num/den scaled by 2^bits, ties upward.
    function automatic logic [63:0] scaled_ratio(logic [63:0] num, logic [63:0] den,
                                                  int bits);
        logic [127:0] wide;
        wide = ({64'd0, num} << bits) + {65'd0, den[63:1]} + {127'd0, den[0]};
        return 64'(wide / {64'd0, den});
    endfunction

    function automatic logic [31:0] gmst_turns(logic [21:0] whole, logic [31:0] frac);
        logic [63:0]  c0, c1, k2, k3, mag, cent, cent2, cube_part;
        logic [127:0] prod;
        longint       days_q32;
        logic         before_epoch;
        logic [31:0]  ang;
        c0 = scaled_ratio(64'd6731054841, 64'd8640000000, 32);
        c1 = scaled_ratio(64'd8640184812866, 64'd3155760000000000, 64);
        k2 = scaled_ratio(64'd93104, 64'd86400000000, 64);
        k3 = scaled_ratio(64'd62, 64'd864000000000, 64);
        days_q32 = (longint'({42'd0, whole}) - EPOCH_DAY) * 64'sd4294967296
                   + longint'({32'd0, frac});
        before_epoch = days_q32 < 0;
        mag = before_epoch ? 64'(-days_q32) : 64'(days_q32);
        prod = {64'd0, mag} * {64'd0, c1};
        if (before_epoch) begin
            prod = -prod;
        end
        ang = frac + c0[31:0] + prod[95:64];
        cent = mag / CENTURY_Q24;
        cent2 = cent * cent;
        prod = {64'd0, cent2} * {64'd0, k2};
        ang = ang + prod[111:80];
        prod = {64'd0, cent2} * {64'd0, k3};
        cube_part = (prod[127:64] * cent) >> 40;
        // The cubic term carries the sign of T, so it flips before the epoch.
        if (before_epoch) begin
            ang = ang + cube_part[31:0];
        end else begin
            ang = ang - cube_part[31:0];
        end
        return ang;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_earth_pos rotate_to_earth(logic [183:0] req);
        t_earth_pos res;
        logic [31:0] shifted;
        longint      cx, cy, cz, nx, cosv, sinv, px, py;
        res.angle = gmst_turns(req[21:0], req[53:22]);
        shifted = res.angle + 32'h2000_0000;
        cx = GAIN_Q30;
        cy = 0;
        cz = longint'({34'd0, shifted[29:0]}) - 64'sd536870912;
        for (int i = 0; i < ROT_STAGES && i < 40; i++) begin
            if (cz >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - longint'({32'd0, atan_tbl[i]});
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + longint'({32'd0, atan_tbl[i]});
            end
            cx = nx;
        end
        case (shifted[31:30])
            2'd0: begin cosv = cx;  sinv = cy;  end
            2'd1: begin cosv = -cy; sinv = cx;  end
            2'd2: begin cosv = -cx; sinv = -cy; end
            default: begin cosv = cy; sinv = -cx; end
        endcase
        px = longint'(signed'(req[85:54]));
        py = longint'(signed'(req[117:86]));
        res.earth_x = 32'(clamp32((cosv * px + sinv * py + 64'sd536870912) >>> 30));
        res.earth_y = 32'(clamp32((cosv * py - sinv * px + 64'sd536870912) >>> 30));
        res.earth_z = req[149:118];
        return res;
    endfunction

    task automatic report_miss(string what, logic [31:0] want, logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch in %s: expected %h, got %h (result %0d)",
                     what, want, got, o_checked);
        end
    endtask

    assign o_pending = earth_q.size();

    always @(posedge i_clk) begin
        t_earth_pos want, got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                earth_q = {earth_q, rotate_to_earth(i_s_tdata)};
            end
            if (i_m_tvalid && i_m_tready) begin
                got.earth_x = i_m_tdata[31:0];
                got.earth_y = i_m_tdata[63:32];
                got.earth_z = i_m_tdata[95:64];
                got.angle = i_m_tdata[127:96];
                if (earth_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result %h with nothing outstanding", i_m_tdata);
                    end
                end else begin
                    want = earth_q.pop_front();
                    if (want.earth_x !== got.earth_x) report_miss("earth_x", want.earth_x, got.earth_x);
                    if (want.earth_y !== got.earth_y) report_miss("earth_y", want.earth_y, got.earth_y);
                    if (want.earth_z !== got.earth_z) report_miss("earth_z", want.earth_z, got.earth_z);
                    if (want.angle !== got.angle) report_miss("sidereal_angle", want.angle, got.angle);
                end
                o_checked++;
            end
        end
    end

endmodule

>>> tb/tb.sv
module tb;

    // Pipeline depth: ten polynomial stages, 32 CORDIC cells, two output stages.
    localparam int PIPE_DEPTH = 44;
    localparam int RANDOM_ITEMS = 1100;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [183:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    int           fail_count;
    int           pending;
    int           checked;

    // Idle percentages for the current phase, and the receiver hold-off request.
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  hold_left;
    int  sent_count;

    gmst_frame_rotation_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    gfr_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The receiver either stalls at random or, on request, holds off for a long
    // stretch so that the pipeline fills and the input side backs up.
    always @(posedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left <= 300;
            m_tready <= 1'b0;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            hold_left <= 0;
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request and waits for it to be accepted. Afterwards each cycle
    // is an idle one with the sender's idle percentage, until the next request.
    task automatic send_request(logic [21:0] whole, logic [31:0] frac,
                                logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        s_tvalid <= 1'b1;
        s_tdata <= {34'd0, pz, py, px, frac, whole};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        sent_count++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(16'hFFFF)) - 32768);
            3, 4: return 32'(signed'($urandom_range(32'd15000000)) - 32'sd7500000);
            default: return $urandom();
        endcase
    endfunction

    // Mostly dates from recent decades, with the full day range mixed in.
    function automatic logic [21:0] pick_day();
        case ($urandom_range(7))
            0: return 22'($urandom());
            1: return 22'($urandom_range(2451545 + 3, 2451545 - 3));
            2: return $urandom_range(1) ? 22'h3F_FFFF : 22'd0;
            default: return 22'($urandom_range(2470000, 2440000));
        endcase
    endfunction

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        i_rst_n = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b0;
        sent_count = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the epoch itself, the day just before it, the ends of the day
        // and fraction ranges, and positions at full scale so that the rotated
        // coordinates saturate near an eighth of a turn.
        send_request(22'd2451545, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(22'd2451545, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(22'd2451544, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        send_request(22'd2451544, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        send_request(22'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_request(22'd0, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0);
        send_request(22'h3F_FFFF, 32'd0, 32'h8000_0000, 32'd0, 32'h8000_0000);
        send_request(22'h3F_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(22'd2460000, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        send_request(22'd2460000, 32'h2000_0000, 32'hFFFF_FFFF, 32'd1, 32'd5);
        for (int q = 0; q < 8; q++) begin
            send_request(22'd2451545 + 22'(q), 32'(q) << 29, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'(q));
        end
        send_request(22'd2455000, 32'h1234_5678, 32'd6_800_000, 32'hFF99_0000, 32'd7000);
        drain_results();

        // Random phases: receiver idles more, then sender idles more, then neither.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 71 : 0;
            recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 26 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                if (phase == 2 && n == 40) begin
                    hold_request <= 1'b1;
                end
                if (phase == 2 && n == 42) begin
                    hold_request <= 1'b0;
                end
                if (phase == 1 && n == 150) begin
                    drain_results();
                end
                send_request(pick_day(), $urandom(), pick_coord(), pick_coord(), pick_coord());
            end
        end

        drain_results();
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d rotated positions across epoch,",
                 sent_count, checked);
        $display("full-range dates, saturating positions and three stall patterns.");
        if (fail_count == 0) begin
            $display("gmst_frame_rotation_core regression: pass");
        end else begin
            $display("gmst_frame_rotation_core regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("gmst_frame_rotation_core regression: fail");
        $finish;
    end

endmodule

>>> gmst_frame_rotation_core.f
design/gfr_pkg.sv
design/gfr_gmst.sv
design/gfr_cell.sv
design/gfr_cordic.sv
design/gfr_rot.sv
design/gmst_frame_rotation_core.sv
tb/gfr_checker.sv
tb/tb.sv
